// File: hdl/uart_rx_event_queue_core_defines.svh
// ----------------------------------------------------------------------------
// uart_rx_event_queue_core_defines.svh
// Assertion macros used by the urxq_back module of the UART receive event queue.
// ----------------------------------------------------------------------------
`ifndef UART_RX_EVENT_QUEUE_CORE_DEFINES_SVH
`define UART_RX_EVENT_QUEUE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define URXQ_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define URXQ_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) cond |=> prop) else $error(msg);
`else
`define URXQ_ASSERT(lbl, clk, rstn, prop, msg)
`define URXQ_ASSERT_NEXT(lbl, clk, rstn, cond, prop, msg)
`endif

`endif

// File: hdl/urxq_pkg.sv
// ----------------------------------------------------------------------------
// urxq_pkg
// Types and constants of the UART receive event queue.
// ----------------------------------------------------------------------------
package urxq_pkg;

    localparam int FIFO_DEPTH_DEFAULT = 64;
    localparam int QUEUE_DEPTH        = 2;
    localparam int EV_W               = 13;
    localparam int COUNT_W            = 7;
    localparam int S_TDATA_W          = 16;
    localparam int M_TDATA_W          = 24;
    localparam int DATA_WORD_W        = 9;

    typedef struct packed {
        logic       idle;
        logic       parity_err;
        logic       frame_err;
        logic       brk;
        logic       data_ok;
        logic [7:0] ch;
    } event_t;

    typedef struct packed {
        logic   is_pop;
        logic   push;
        logic   rxne_upd;
        logic   rxne_val;
        event_t ev;
    } item_t;

endpackage

// File: hdl/urxq_front.sv
// ----------------------------------------------------------------------------
// urxq_front
// Accepts input items and classifies status snapshots into events.
// ----------------------------------------------------------------------------
module urxq_front (
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // rx_not_empty, framing_error, parity_error, idle_line, data_word[8:0], pad
    input  logic [urxq_pkg::S_TDATA_W-1:0]    s_tdata,
    // cmd
    input  logic                              s_tuser,
    output logic                              q_valid,
    input  logic                              q_ready,
    output urxq_pkg::item_t                   q_item
);

    logic                                 rxne;
    logic                                 fe;
    logic                                 pe;
    logic                                 idle;
    logic [urxq_pkg::DATA_WORD_W-1:0]     word;

    assign rxne     = s_tdata[0];
    assign fe       = s_tdata[1];
    assign pe       = s_tdata[2];
    assign idle     = s_tdata[3];
    assign word     = s_tdata[12:4];
    assign q_valid  = s_tvalid;
    assign s_tready = q_ready;

    always_comb begin
        q_item        = '0;
        q_item.is_pop = s_tuser;
        if (!s_tuser) begin
            if (rxne) begin
                q_item.push       = 1'b1;
                q_item.ev.ch      = word[7:0];
                q_item.ev.data_ok = 1'b1;
                if (fe) begin
                    if (word == '0) begin
                        q_item.ev.brk     = 1'b1;
                        q_item.ev.data_ok = 1'b0;
                        q_item.rxne_upd   = 1'b1;
                        q_item.rxne_val   = 1'b0;
                    end else begin
                        q_item.ev.frame_err = 1'b1;
                    end
                end
                if (pe) begin
                    q_item.ev.parity_err = 1'b1;
                    q_item.ev.frame_err  = 1'b1;
                    q_item.ev.data_ok    = 1'b0;
                end
            end
            if (idle) begin
                q_item.ev.idle  = 1'b1;
                q_item.push     = 1'b1;
                q_item.rxne_upd = 1'b1;
                q_item.rxne_val = 1'b1;
            end
        end
    end

endmodule

// File: hdl/urxq_queue.sv
// ----------------------------------------------------------------------------
// urxq_queue
// Two-entry register queue between the classifier and the event FIFO.
// ----------------------------------------------------------------------------
module urxq_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  urxq_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_ready,
    output urxq_pkg::item_t out_item
);

    localparam int IDX_W = $clog2(urxq_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(urxq_pkg::QUEUE_DEPTH + 1);

    urxq_pkg::item_t    entry_reg [urxq_pkg::QUEUE_DEPTH];
    logic [IDX_W-1:0]   wr_idx_reg;
    logic [IDX_W-1:0]   wr_idx_next;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [IDX_W-1:0]   rd_idx_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               do_wr;
    logic               do_rd;

    assign in_ready  = (cnt_reg != CNT_W'(urxq_pkg::QUEUE_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = entry_reg[rd_idx_reg];
    assign do_wr     = in_valid && in_ready;
    assign do_rd     = out_valid && out_ready;

    always_comb begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        cnt_next    = cnt_reg;
        if (do_wr) begin
            wr_idx_next = (wr_idx_reg == IDX_W'(urxq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_idx_reg + 1'b1;
        end
        if (do_rd) begin
            rd_idx_next = (rd_idx_reg == IDX_W'(urxq_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_idx_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_rd && !do_wr) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wr_idx_reg] <= in_item;
        end
    end

endmodule

// File: hdl/urxq_back.sv
// ----------------------------------------------------------------------------
// urxq_back
// Event ring FIFO with overwrite of the oldest entry, and the result register.
// ----------------------------------------------------------------------------
`include "uart_rx_event_queue_core_defines.svh"

module urxq_back #(
    parameter int FIFO_DEPTH = urxq_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  urxq_pkg::item_t                q_item,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ev_char[7:0], ev_has_data, ev_break, ev_frame_err, ev_parity_err, ev_idle,
    // queued_count[6:0], rxne_irq_enabled, pad
    output logic [urxq_pkg::M_TDATA_W-1:0] m_tdata,
    // pop_valid
    output logic                           m_tuser
);

    localparam int PTR_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    urxq_pkg::event_t   mem [FIFO_DEPTH];
    urxq_pkg::event_t   rd_data_reg;
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               rxne_reg;
    logic               rxne_next;
    logic               m_valid_reg;
    logic               pop_reg;
    logic               take;
    logic               full;
    logic               do_push;
    logic               do_pop;
    urxq_pkg::event_t   ev_out;

    assign q_ready = !m_valid_reg || m_tready;
    assign take    = q_valid && q_ready;
    assign full    = (cnt_reg == CNT_W'(FIFO_DEPTH));
    assign do_push = take && !q_item.is_pop && q_item.push;
    assign do_pop  = take && q_item.is_pop && (cnt_reg != '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        rxne_next   = rxne_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (full) begin
                rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            cnt_next    = cnt_reg - 1'b1;
        end
        if (take && !q_item.is_pop && q_item.rxne_upd) begin
            rxne_next = q_item.rxne_val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            rxne_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
            pop_reg     <= 1'b0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
            rxne_reg   <= rxne_next;
            if (take) begin
                m_valid_reg <= 1'b1;
                pop_reg     <= do_pop;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_item.ev;
        end
        if (do_pop) begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    assign ev_out   = pop_reg ? rd_data_reg : '0;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = pop_reg;
    assign m_tdata  = {3'b000, rxne_reg, urxq_pkg::COUNT_W'(cnt_reg), ev_out};

    `URXQ_ASSERT(a_count_bound, aclk, aresetn, cnt_reg <= CNT_W'(FIFO_DEPTH), "count overflow")
    `URXQ_ASSERT(a_ptr_match, aclk, aresetn, (SUM_W'(rd_ptr_reg) + SUM_W'(cnt_reg) == SUM_W'(wr_ptr_reg)) || (SUM_W'(rd_ptr_reg) + SUM_W'(cnt_reg) == SUM_W'(wr_ptr_reg) + SUM_W'(FIFO_DEPTH)), "pointers and count disagree")
    `URXQ_ASSERT_NEXT(a_empty_pop, aclk, aresetn, take && q_item.is_pop && (cnt_reg == '0), !pop_reg && (cnt_reg == '0), "pop on empty FIFO returned an event")
    `URXQ_ASSERT_NEXT(a_full_push, aclk, aresetn, do_push && full, cnt_reg == CNT_W'(FIFO_DEPTH), "push on full FIFO changed the count")

endmodule

// File: hdl/uart_rx_event_queue_core.sv
// ----------------------------------------------------------------------------
// uart_rx_event_queue_core
// UART receive status event queue: classifies status snapshots into events
// held in a ring FIFO and returns the oldest event on a pop request.
// ----------------------------------------------------------------------------
// Usage: the s_ channel carries one item per handshake. s_tuser low means a
// receiver status snapshot in s_tdata; s_tuser high requests a pop and the
// status bits are ignored. Every item produces exactly one item on the m_
// channel with the popped event (all zero unless m_tuser is high), the FIFO
// fill level after the item and the receive interrupt enable.
// m_tvalid rises once an accepted item has passed the two-entry queue and
// has been taken into the result register. While m_tready stays high the
// block sustains one item per cycle: a two-entry queue feeds the FIFO stage,
// which reads its event memory with one registered read per item.
// A push into a full FIFO drops the oldest event; a pop on an empty FIFO
// returns m_tuser low. When m_tready is low the result is held, the queue
// fills and s_tready drops after two more items.
// After reset the FIFO is empty and the interrupt enable is set; the event
// memory holds no defined contents, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module uart_rx_event_queue_core #(
    parameter int FIFO_DEPTH = urxq_pkg::FIFO_DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // rx_not_empty, framing_error, parity_error, idle_line, data_word[8:0], pad
    input  logic [urxq_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ev_char[7:0], ev_has_data, ev_break, ev_frame_err, ev_parity_err, ev_idle,
    // queued_count[6:0], rxne_irq_enabled, pad
    output logic [urxq_pkg::M_TDATA_W-1:0] m_tdata,
    // pop_valid
    output logic                           m_tuser
);

    logic            f_valid;
    logic            f_ready;
    urxq_pkg::item_t f_item;
    logic            b_valid;
    logic            b_ready;
    urxq_pkg::item_t b_item;

    urxq_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_item   (f_item)
    );

    urxq_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    urxq_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (b_valid),
        .q_ready  (b_ready),
        .q_item   (b_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UART receive status event queue core.
// A directed opening covers plain data, breaks, framing and parity errors,
// idle lines, ignored error flags and pops on an empty FIFO. Random traffic
// then drives phases that are rich in snapshots and phases rich in pops, so
// the FIFO overflows and drains. Both stream sides stall at random. A shadow
// model classifies every accepted item, and every result is checked field
// by field against the oldest expected result.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int DEPTH = urxq_pkg::FIFO_DEPTH_DEFAULT;

    typedef struct packed {
        logic                         pop_valid;
        urxq_pkg::event_t             ev;
        logic [urxq_pkg::COUNT_W-1:0] count;
        logic                         irq_en;
    } result_t;

    class rx_event_ledger;
        urxq_pkg::event_t store[DEPTH];
        int      rd_ptr;
        int      wr_ptr;
        int      fill;
        logic    irq_en;
        result_t awaited_results[$];
        int      errors;
        int      printed;
        int      popped_events;
        int      empty_pops;
        int      dropped_events;
        int      breaks_seen;
        int      max_fill;

        function new();
            rd_ptr = 0;
            wr_ptr = 0;
            fill = 0;
            irq_en = 1'b1;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task report(input string msg);
            errors++;
            if (printed < 40) begin
                printed++;
                $display("MISMATCH at %0t: %s", $realtime, msg);
            end
        endtask

        function void append_event(input urxq_pkg::event_t e);
            if (fill >= DEPTH) begin
                rd_ptr = (rd_ptr + 1) % DEPTH;
                fill--;
                dropped_events++;
            end
            store[wr_ptr] = e;
            wr_ptr = (wr_ptr + 1) % DEPTH;
            fill++;
            if (fill > max_fill) max_fill = fill;
        endfunction

        // Classifies one accepted item and records the result it must give.
        function void note_item(input logic pop_req,
                                input logic [urxq_pkg::S_TDATA_W-1:0] d);
            urxq_pkg::event_t e;
            result_t r;
            logic    fresh;
            logic [urxq_pkg::DATA_WORD_W-1:0] word;
            e = '0;
            r = '0;
            fresh = 1'b0;
            word = d[12:4];
            if (!pop_req) begin
                if (d[0]) begin
                    fresh = 1'b1;
                    e.ch = word[7:0];
                    e.data_ok = 1'b1;
                    if (d[1]) begin
                        if (word == '0) begin
                            e.brk = 1'b1;
                            e.data_ok = 1'b0;
                            irq_en = 1'b0;
                            breaks_seen++;
                        end else begin
                            e.frame_err = 1'b1;
                        end
                    end
                    if (d[2]) begin
                        e.parity_err = 1'b1;
                        e.frame_err = 1'b1;
                        e.data_ok = 1'b0;
                    end
                end
                if (d[3]) begin
                    e.idle = 1'b1;
                    fresh = 1'b1;
                    irq_en = 1'b1;
                end
                if (fresh) append_event(e);
            end else if (fill > 0) begin
                r.pop_valid = 1'b1;
                r.ev = store[rd_ptr];
                rd_ptr = (rd_ptr + 1) % DEPTH;
                fill--;
                popped_events++;
            end else begin
                empty_pops++;
            end
            r.count = fill[urxq_pkg::COUNT_W-1:0];
            r.irq_en = irq_en;
            awaited_results.push_back(r);
        endfunction

        task check_item(input logic pop_valid, input logic [urxq_pkg::M_TDATA_W-1:0] d);
            result_t want;
            urxq_pkg::event_t got;
            if (awaited_results.size() == 0) begin
                report("result arrived with nothing expected");
                return;
            end
            want = awaited_results.pop_front();
            got = d[urxq_pkg::EV_W-1:0];
            if (pop_valid !== want.pop_valid)
                report($sformatf("pop_valid %b, expected %b", pop_valid, want.pop_valid));
            if (got.ch !== want.ev.ch)
                report($sformatf("ev_char %h, expected %h", got.ch, want.ev.ch));
            if (got.data_ok !== want.ev.data_ok)
                report($sformatf("ev_has_data %b, expected %b", got.data_ok,
                                 want.ev.data_ok));
            if (got.brk !== want.ev.brk)
                report($sformatf("ev_break %b, expected %b", got.brk, want.ev.brk));
            if (got.frame_err !== want.ev.frame_err)
                report($sformatf("ev_frame_err %b, expected %b", got.frame_err,
                                 want.ev.frame_err));
            if (got.parity_err !== want.ev.parity_err)
                report($sformatf("ev_parity_err %b, expected %b", got.parity_err,
                                 want.ev.parity_err));
            if (got.idle !== want.ev.idle)
                report($sformatf("ev_idle %b, expected %b", got.idle, want.ev.idle));
            if (d[19:13] !== want.count)
                report($sformatf("queued_count %0d, expected %0d", d[19:13], want.count));
            if (d[20] !== want.irq_en)
                report($sformatf("rxne_irq_enabled %b, expected %b", d[20], want.irq_en));
        endtask
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [urxq_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [urxq_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;

    rx_event_ledger ledger = new();
    int  sent_items;
    int  sink_stall_odds;
    bit  long_hold_req;

    uart_rx_event_queue_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                ledger.note_item(s_tuser, s_tdata);
                sent_items++;
            end
            if (m_tvalid && m_tready) ledger.check_item(m_tuser, m_tdata);
        end
    end

    function automatic logic [urxq_pkg::S_TDATA_W-1:0] pack_status(
        input bit rx, input bit fe, input bit pe, input bit idle,
        input logic [urxq_pkg::DATA_WORD_W-1:0] word
    );
        logic [urxq_pkg::S_TDATA_W-1:0] d;
        d = '0;
        d[0] = rx;
        d[1] = fe;
        d[2] = pe;
        d[3] = idle;
        d[12:4] = word;
        return d;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_item(input logic pop_req,
                             input logic [urxq_pkg::S_TDATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tuser <= pop_req;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic source_gap(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (ledger.pending() != 0) @(negedge aclk);
    endtask

    task automatic send_random_item(input int pop_pct);
        bit rx;
        bit fe;
        bit pe;
        bit idle;
        logic [urxq_pkg::DATA_WORD_W-1:0] word;
        word = urxq_pkg::DATA_WORD_W'($urandom_range(0, 511));
        if ($urandom_range(1, 100) <= pop_pct) begin
            send_item(1'b1, pack_status(1'($urandom), 1'($urandom), 1'($urandom),
                                        1'($urandom), word));
        end else if ($urandom_range(0, 9) == 0) begin
            send_item(1'b0, pack_status(1'b0, 1'($urandom), 1'($urandom),
                                        1'($urandom), word));
        end else begin
            rx = 1'b1;
            fe = ($urandom_range(0, 4) == 0);
            pe = ($urandom_range(0, 6) == 0);
            idle = ($urandom_range(0, 6) == 0);
            if (fe && $urandom_range(0, 1)) word = '0;
            send_item(1'b0, pack_status(rx, fe, pe, idle, word));
        end
    endtask

    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (60) @(negedge aclk);
                m_tready <= 1'b1;
            end else if (sink_stall_odds > 0 && $urandom_range(1, 100) <= sink_stall_odds) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(negedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", ledger.pending());
        $display("simulation failed");
        $finish;
    end

    initial begin
        int pop_mix[8];
        int src_odds;
        pop_mix = '{15, 50, 85, 5, 60, 95, 40, 50};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = 1'b0;
        s_tdata = '0;
        sink_stall_odds = 0;
        long_hold_req = 1'b0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(1'b1, pack_status(1'b1, 1'b1, 1'b1, 1'b1, 9'h1ff));
        send_item(1'b0, pack_status(1'b0, 1'b0, 1'b0, 1'b0, 9'h1ff));
        send_item(1'b0, pack_status(1'b0, 1'b1, 1'b1, 1'b0, 9'h000));
        send_item(1'b0, pack_status(1'b1, 1'b0, 1'b0, 1'b0, 9'h000));
        send_item(1'b0, pack_status(1'b1, 1'b0, 1'b0, 1'b0, 9'h1ff));
        send_item(1'b0, pack_status(1'b1, 1'b1, 1'b0, 1'b0, 9'h100));
        send_item(1'b0, pack_status(1'b1, 1'b1, 1'b0, 1'b0, 9'h000));
        send_item(1'b0, pack_status(1'b1, 1'b0, 1'b1, 1'b0, 9'h055));
        send_item(1'b0, pack_status(1'b1, 1'b1, 1'b1, 1'b0, 9'h000));
        send_item(1'b0, pack_status(1'b0, 1'b0, 1'b0, 1'b1, 9'h0c3));
        send_item(1'b0, pack_status(1'b1, 1'b1, 1'b0, 1'b1, 9'h000));
        send_item(1'b0, pack_status(1'b1, 1'b0, 1'b1, 1'b1, 9'h0aa));
        send_item(1'b0, pack_status(1'b1, 1'b1, 1'b1, 1'b1, 9'h1ff));
        repeat (11) send_item(1'b1, pack_status(1'b1, 1'b1, 1'b1, 1'b1, 9'h1ff));

        for (int n = 0; n < 800; n++) begin
            if (n % 100 == 0) begin
                sink_stall_odds = (n < 700) ? $urandom_range(0, 30) : 0;
                if (n == 200) long_hold_req = 1'b1;
                if (n == 400) wait_drained();
            end
            src_odds = (n < 700 && (n / 100) % 3 != 1) ? 20 : 0;
            send_random_item(pop_mix[n / 100]);
            if (src_odds > 0 && $urandom_range(1, 100) <= src_odds)
                source_gap($urandom_range(1, 5));
        end

        wait_drained();
        repeat (10) @(negedge aclk);
        $display("Ran %0d items: %0d events popped, %0d pops on an empty queue.",
                 sent_items, ledger.popped_events, ledger.empty_pops);
        $display("Saw %0d breaks, %0d events dropped on overflow, peak fill %0d.",
                 ledger.breaks_seen, ledger.dropped_events, ledger.max_fill);
        if (ledger.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/urxq_pkg.sv
hdl/urxq_front.sv
hdl/urxq_queue.sv
hdl/urxq_back.sv
hdl/uart_rx_event_queue_core.sv
test/tb_top.sv
